@@ hw/rtl/gmp_pkg.sv @@
// Shared widths, register indexes and neighbour control type for the grid max-path block.
package gmp_pkg;

  localparam int CELL_W      = 16;
  localparam int SUM_W       = 32;
  localparam int ROW_CNT_W   = 7;
  localparam int COL_CNT_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET    = 7'd4;
  localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RESET = 16'd4;

  // which left neighbours take part in the current cell's update
  typedef struct packed {
    logic first_col;
    logic has_up;
    logic has_below;
  } gmp_nbr_ctrl_t;

endpackage

@@ hw/rtl/gmp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/gmp_cell_dp.sv @@
// Cell update: three-way max over the left neighbours, add, and saturate.
module gmp_cell_dp import gmp_pkg::*; (
  input  gmp_nbr_ctrl_t    ctrl,
  input  logic [SUM_W-1:0] up,
  input  logic [SUM_W-1:0] here,
  input  logic [SUM_W-1:0] below,
  input  logic [CELL_W-1:0] gold,
  output logic [SUM_W-1:0] best,
  output logic             clip
);

  logic [SUM_W-1:0] prev;
  logic [SUM_W-1:0] max_a;
  logic [SUM_W:0]   sum;

  always_comb begin
    max_a = here;
    if (ctrl.has_up && up > max_a) begin
      max_a = up;
    end
    if (ctrl.has_below && below > max_a) begin
      max_a = below;
    end
    prev = ctrl.first_col ? '0 : max_a;
    sum  = {1'b0, prev} + (SUM_W + 1)'(gold);
    clip = sum[SUM_W];
    best = clip ? '1 : sum[SUM_W-1:0];
  end

endmodule

@@ hw/rtl/grid_max_path_dp_unit.sv @@
// Grid max-path top: input register, cell update, column store and result register.
// Throughput: one cell per cycle; the column store is read two rows ahead of the cell being
// updated, so no bubbles. A grid's last cell waits only while the previous result is unaccepted.
// A cell waits in the input register and is updated when it fires; out_valid for a grid rises
// at the same edge at which its last cell is updated.
// Reset (rst, synchronous): registers return to 4 rows by 4 columns, a new grid starts.
// The column store needs no clearing: only entries written in the current grid are read.
module grid_max_path_dp_unit import gmp_pkg::*; #(
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CELL_W-1:0]     cell_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      max_total,
  output logic                  saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = COL_CNT_W + 1;

  logic [ROW_CNT_W-1:0] row_count;
  logic [COL_CNT_W-1:0] column_count;

  logic                 in_full;
  logic [CELL_W-1:0]    cell_q;

  logic [AW-1:0]        row_pos;
  logic [COL_CNT_W-1:0] col_pos;
  logic [SUM_W-1:0]     run_max;
  logic                 clip_seen;

  logic [SUM_W-1:0]     up_reg;
  logic [SUM_W-1:0]     here_reg;
  logic [SUM_W-1:0]     row0_best;
  logic [SUM_W-1:0]     row1_best;
  logic                 use_row1;
  logic [SUM_W-1:0]     ram_q;

  logic [RW-1:0]        rows_eff;
  logic [COL_CNT_W-1:0] cols_eff;
  logic [AW-1:0]        r_eff;
  logic                 last_row;
  logic                 last_col;
  logic                 last_cell;
  logic                 fire;
  logic [SUM_W-1:0]     below_val;
  logic [SUM_W-1:0]     best;
  logic                 clip_now;
  logic [SUM_W-1:0]     run_max_next;
  gmp_nbr_ctrl_t        nbr;

  always_comb begin
    if (row_count == '0) begin
      rows_eff = RW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count);
    end
    cols_eff = (column_count == '0) ? COL_CNT_W'(1) : column_count;

    if ((RW + 1)'(row_pos) >= (RW + 1)'(rows_eff)) begin
      r_eff = AW'(rows_eff - RW'(1));
    end else begin
      r_eff = row_pos;
    end

    last_row  = ((RW + 1)'(r_eff) + (RW + 1)'(1)) >= (RW + 1)'(rows_eff);
    last_col  = (CW'(col_pos) + CW'(1)) >= CW'(cols_eff);
    last_cell = last_row && last_col;

    nbr.first_col = (col_pos == '0);
    nbr.has_up    = (r_eff != '0);
    nbr.has_below = !last_row;

    below_val = use_row1 ? row1_best : ram_q;

    run_max_next = (last_col && best > run_max) ? best : run_max;
  end

  // a non-final cell never waits for the output slot
  assign fire      = in_full && (!last_cell || !out_valid || out_ready);
  assign in_ready  = !in_full || fire;
  assign cfg_ready = 1'b1;

  gmp_cell_dp u_cell (
    .ctrl  (nbr),
    .up    (up_reg),
    .here  (here_reg),
    .below (below_val),
    .gold  (cell_q),
    .best  (best),
    .clip  (clip_now)
  );

  // read two rows ahead: the next cell's lower neighbour from the previous column
  gmp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (r_eff),
    .wr_data (best),
    .rd_en   (fire),
    .rd_addr (AW'(r_eff + AW'(2))),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cell_q <= cell_value;
    end
    if (fire) begin
      if (r_eff == '0) begin
        row0_best <= best;
      end
      if (r_eff == AW'(1)) begin
        row1_best <= best;
      end
      if (!last_row) begin
        up_reg   <= here_reg;
        here_reg <= below_val;
      end else begin
        here_reg <= (r_eff == '0) ? best : row0_best;
      end
      if (last_cell) begin
        max_total <= run_max_next;
        saturated <= clip_seen | clip_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
      row_pos      <= '0;
      col_pos      <= '0;
      run_max      <= '0;
      clip_seen    <= 1'b0;
      use_row1     <= 1'b1;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end

      if (fire && last_cell) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_COUNT: begin
            row_count <= cfg_data[ROW_CNT_W-1:0];
          end
          REG_COLUMN_COUNT: begin
            column_count <= cfg_data[COL_CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // a register write restarts the grid
      if (cfg_valid && (cfg_index inside {REG_ROW_COUNT, REG_COLUMN_COUNT})) begin
        row_pos   <= '0;
        col_pos   <= '0;
        run_max   <= '0;
        clip_seen <= 1'b0;
        use_row1  <= 1'b1;
      end else if (fire) begin
        if (!last_row) begin
          row_pos   <= AW'(r_eff + AW'(1));
          use_row1  <= 1'b0;
          run_max   <= run_max_next;
          clip_seen <= clip_seen | clip_now;
        end else begin
          row_pos  <= '0;
          use_row1 <= 1'b1;
          if (!last_col) begin
            col_pos   <= col_pos + COL_CNT_W'(1);
            run_max   <= run_max_next;
            clip_seen <= clip_seen | clip_now;
          end else begin
            col_pos   <= '0;
            run_max   <= '0;
            clip_seen <= 1'b0;
          end
        end
      end
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (RW + 1)'(row_pos) < (RW + 1)'(rows_eff))
    else $error("row position beyond row count");

  a_row1_at_col_start: assert property (@(posedge clk) disable iff (rst)
    use_row1 |-> (row_pos == '0))
    else $error("row-one window source selected away from row zero");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (fire && last_cell) |=> out_valid)
    else $error("last cell of grid gave no result");

  a_final_not_lost: assert property (@(posedge clk) disable iff (rst)
    (in_full && last_cell && out_valid && !out_ready) |-> !fire)
    else $error("final cell updated while result slot is full");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the grid max-path block: directed grids, register extremes and random grids.
`timescale 1ns / 100ps

module tb_top;
  import gmp_pkg::*;

  localparam int GRID_ROWS     = 64;
  localparam int BLOCK_LATENCY = 4;
  localparam int STUCK_LIMIT   = 2000;
  localparam int RANDOM_CELLS  = 200;
  localparam int RANDOM_GRIDS  = 15;
  localparam int LONG_COLUMNS  = 150;

  // indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [SUM_W-1:0] total;
    logic             sat;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid;
  logic                  in_ready;
  logic [CELL_W-1:0]     cell_value;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SUM_W-1:0]      max_total;
  logic                  saturated;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [ROW_CNT_W-1:0] row_cfg;
  logic [COL_CNT_W-1:0] col_cfg;
  logic [SUM_W-1:0]     best_sums [GRID_ROWS];
  logic [SUM_W-1:0]     above_old;
  int unsigned          cur_row;
  int unsigned          cur_col;
  logic [SUM_W-1:0]     final_col_max;
  logic                 clipped;

  path_result_t expected_totals[$];
  path_result_t head;

  int unsigned faults;
  int unsigned cells_sent;
  int unsigned grids_done;
  int unsigned totals_checked;
  int unsigned reg_writes;
  int unsigned stuck_cycles;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned stall_left;

  grid_max_path_dp_unit #(.MAX_ROWS(GRID_ROWS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .max_total  (max_total),
    .saturated  (saturated),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned rows_in_grid();
    if (row_cfg == 0) return 1;
    if (row_cfg > GRID_ROWS) return GRID_ROWS;
    return 32'(row_cfg);
  endfunction

  function automatic int unsigned cols_in_grid();
    return (col_cfg == 0) ? 1 : 32'(col_cfg);
  endfunction

  function automatic void start_grid();
    above_old     = '0;
    cur_row       = 0;
    cur_col       = 0;
    final_col_max = '0;
    clipped       = 1'b0;
  endfunction

  // best(r,c) = cell + max of the up to three left neighbours
  function automatic void predict_cell(input logic [CELL_W-1:0] v);
    int unsigned     n_rows;
    int unsigned     n_cols;
    int unsigned     r;
    logic [SUM_W-1:0] prev;
    logic [SUM_W-1:0] here_old;
    logic [SUM_W:0]   sum;
    logic [SUM_W-1:0] best;
    logic             last_row;
    logic             last_col;
    path_result_t     res;
    n_rows = rows_in_grid();
    n_cols = cols_in_grid();
    r = (cur_row >= n_rows) ? n_rows - 1 : cur_row;
    last_row = (r + 1 >= n_rows);
    last_col = (cur_col + 1 >= n_cols);
    here_old = best_sums[r];
    prev = '0;
    if (cur_col > 0) begin
      prev = here_old;
      if (r > 0 && above_old > prev) prev = above_old;
      if (!last_row && best_sums[r+1] > prev) prev = best_sums[r+1];
    end
    sum = {1'b0, prev} + {{(SUM_W-CELL_W+1){1'b0}}, v};
    if (sum[SUM_W]) begin
      best = '1;
      clipped = 1'b1;
    end else begin
      best = sum[SUM_W-1:0];
    end
    above_old = here_old;
    best_sums[r] = best;
    if (last_col && best > final_col_max) final_col_max = best;
    if (!last_row) begin
      cur_row = r + 1;
      return;
    end
    cur_row = 0;
    above_old = '0;
    if (!last_col) begin
      cur_col = cur_col + 1;
      return;
    end
    res.total = final_col_max;
    res.sat   = clipped;
    expected_totals.push_back(res);
    grids_done++;
    start_grid();
  endfunction

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CELL_W-1:0] random_cell();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CELL_W'($urandom_range(0, 15));
      default: return CELL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_cell(input logic [CELL_W-1:0] v);
    int unsigned gap;
    gap = pick_gap(send_gap_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cell(v);
    cells_sent++;
  endtask

  task automatic send_random_cells(input int unsigned n);
    repeat (n) send_cell(random_cell());
  endtask

  // drop valid, let every expected total come back, then cover the pipeline
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROW_COUNT: begin
        row_cfg = data[ROW_CNT_W-1:0];
        start_grid();
      end
      REG_COLUMN_COUNT: begin
        col_cfg = data[COL_CNT_W-1:0];
        start_grid();
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic report_bad(input string what, input path_result_t want);
    if (faults < 10)
      $display("%0t: %s: expected total %0d sat %0d, got total %0d sat %0d",
               $realtime, what, want.total, want.sat, max_total, saturated);
    faults++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        head.total = 'x;
        head.sat   = 1'bx;
        report_bad("total with no grid outstanding", head);
      end else begin
        head = expected_totals.pop_front();
        if (max_total !== head.total || saturated !== head.sat) report_bad("total mismatch", head);
        totals_checked++;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // reset shape, diagonal path, and two grids back to back
  task automatic test_default_grid();
    logic [CELL_W-1:0] diag [16];
    diag = '{16'hFFFF, 16'd0, 16'd0, 16'd7, 16'd0, 16'hFFFF, 16'd0, 16'd9,
             16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd5, 16'd0, 16'd0, 16'hFFFF};
    send_gap_pct   = 30;
    recv_stall_pct = 30;
    foreach (diag[i]) send_cell(diag[i]);
    foreach (diag[i]) send_cell(~diag[i]);
    settle_block();
  endtask

  // one-cell grids, zero counts taken as one
  task automatic test_single_cell();
    write_reg(REG_ROW_COUNT, 16'd1);
    write_reg(REG_COLUMN_COUNT, 16'd1);
    send_cell(16'hFFFF);
    send_cell(16'd0);
    write_reg(REG_ROW_COUNT, 16'd0);
    write_reg(REG_COLUMN_COUNT, 16'd0);
    send_cell(16'h5A5A);
    settle_block();
  endtask

  // rows above the store depth clamp; upper data bits of the row write are dropped
  task automatic test_row_clamp();
    write_reg(REG_ROW_COUNT, 16'h3FFF);
    write_reg(REG_COLUMN_COUNT, 16'd2);
    send_random_cells(rows_in_grid() * cols_in_grid());
    write_reg(REG_ROW_COUNT, 16'hFF85);
    write_reg(REG_COLUMN_COUNT, 16'd0);
    send_random_cells(rows_in_grid());
    write_reg(REG_ROW_COUNT, 16'd64);
    write_reg(REG_COLUMN_COUNT, 16'd1);
    send_random_cells(rows_in_grid() * cols_in_grid());
    settle_block();
  endtask

  // a write half way through a grid throws the partial grid away
  task automatic test_restart_on_write();
    write_reg(REG_ROW_COUNT, 16'd3);
    write_reg(REG_COLUMN_COUNT, 16'd3);
    send_random_cells(4);
    write_reg(REG_COLUMN_COUNT, 16'd3);
    send_random_cells(9);
    settle_block();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_3, 16'hFFFF);
    send_random_cells(rows_in_grid() * cols_in_grid());
    settle_block();
  endtask

  // long single-row grid of full cells, then the widest column count left part way
  task automatic test_long_grid();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_reg(REG_ROW_COUNT, 16'd1);
    write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(LONG_COLUMNS));
    repeat (LONG_COLUMNS) send_cell(16'hFFFF);
    write_reg(REG_COLUMN_COUNT, 16'hFFFF);
    repeat (20) send_cell(16'hFFFF);
    write_reg(REG_COLUMN_COUNT, 16'd4);
    settle_block();
  endtask

  task automatic test_random_grids();
    int unsigned start_cells;
    int unsigned start_grids;
    int unsigned mode;
    int unsigned n;
    int unsigned k;
    logic [ROW_CNT_W-1:0] rows_new;
    logic [CFG_DATA_W-1:0] cols_new;
    bit cut_short;
    start_cells = cells_sent;
    start_grids = grids_done;
    cut_short = 0;
    while (cells_sent - start_cells < RANDOM_CELLS ||
           grids_done - start_grids < RANDOM_GRIDS) begin
      if ($urandom_range(0, 4) == 0) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else begin
        send_gap_pct   = $urandom_range(10, 50);
        recv_stall_pct = $urandom_range(10, 50);
      end
      mode = $urandom_range(0, 3);
      if (cut_short && mode == 0) mode = 3;
      if (mode == 1 || mode == 3) begin
        k = $urandom_range(0, 19);
        if (k == 0) rows_new = '0;
        else if (k == 1) rows_new = ROW_CNT_W'($urandom_range(65, 127));
        else if (k <= 3) rows_new = ROW_CNT_W'(64);
        else if (k <= 5) rows_new = ROW_CNT_W'($urandom_range(9, 63));
        else rows_new = ROW_CNT_W'($urandom_range(1, 8));
        write_reg(REG_ROW_COUNT,
                  (CFG_DATA_W'($urandom_range(0, 511)) << ROW_CNT_W) | CFG_DATA_W'(rows_new));
        if (rows_in_grid() > 16 && cols_in_grid() > 3) mode = 3;
      end
      if (mode >= 2) begin
        k = $urandom_range(0, 9);
        if (rows_in_grid() > 16) cols_new = CFG_DATA_W'($urandom_range(0, 3));
        else if (k == 0) cols_new = '0;
        else if (k <= 2) cols_new = CFG_DATA_W'($urandom_range(7, 24));
        else cols_new = CFG_DATA_W'($urandom_range(1, 6));
        write_reg(REG_COLUMN_COUNT, cols_new);
      end
      // when the count of grids done is a multiple of eight, hold the sender until the block has drained
      if ((grids_done - start_grids) % 8 == 0) settle_block();
      n = rows_in_grid() * cols_in_grid();
      cut_short = (n > 1 && $urandom_range(0, 9) == 0);
      if (cut_short) n = $urandom_range(1, n - 1);
      send_random_cells(n);
    end
    settle_block();
  endtask

  initial begin
    in_valid   <= 1'b0;
    cell_value <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ROW_COUNT;
    cfg_data   <= '0;
    faults = 0;
    cells_sent = 0;
    grids_done = 0;
    totals_checked = 0;
    reg_writes = 0;
    stuck_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    row_cfg = ROW_COUNT_RESET;
    col_cfg = COLUMN_COUNT_RESET;
    foreach (best_sums[i]) best_sums[i] = '0;
    start_grid();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_grid();
    test_single_cell();
    test_row_clamp();
    test_restart_on_write();
    test_spare_index();
    test_long_grid();
    test_random_grids();

    settle_block();
    repeat (10) @(posedge clk);
    if (expected_totals.size() != 0) begin
      $display("%0d grid totals never arrived", expected_totals.size());
      faults++;
    end
    $display("Covered %0d cells over %0d grids (1 to 64 rows, up to %0d columns), %0d checked",
             cells_sent, grids_done, LONG_COLUMNS, totals_checked);
    $display("%0d register writes incl. zero, clamped, masked and spare-index ones; %0d faults",
             reg_writes, faults);
    if (faults == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ grid_max_path_dp_unit.f @@
hw/rtl/gmp_pkg.sv
hw/rtl/gmp_ram.sv
hw/rtl/gmp_cell_dp.sv
hw/rtl/grid_max_path_dp_unit.sv
tb/tb_top.sv
